/* rtl/core/rhlt_pkg.sv */
// Shared types and constants for the recursive hardware lock table.
`timescale 1ns / 1ps

package rhlt_pkg;

    localparam int unsigned OP_W     = 1;
    localparam int unsigned RES_W    = 6;
    localparam int unsigned CORE_W   = 1;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CHAN_W   = 4;
    localparam int unsigned COUNT_W  = 8;

    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned M_DATA_W = 16;

    localparam logic OP_LOCK   = 1'b0;
    localparam logic OP_UNLOCK = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_PARAM = 2'd1,
        ST_NOSUP = 2'd2,
        ST_BUSY  = 2'd3
    } status_t;

    // Resource mapping, decoded ahead of the table lookup
    typedef struct packed {
        logic              in_range;
        logic              unit1;
        logic              core_ok;
        logic [RES_W-1:0]  chan_full;
    } dec_t;

    typedef struct packed {
        status_t            status;
        logic               unit_id;
        logic [CHAN_W-1:0]  channel;
        logic [COUNT_W-1:0] count_after;
    } result_t;

endpackage

/* rtl/core/rhlt_decode.sv */
// Resource and core decode: range check and unit/channel mapping.
`timescale 1ns / 1ps

module rhlt_decode #(
    parameter int unsigned NUM_RESOURCES     = 32,
    parameter int unsigned NUM_CORES         = 2,
    parameter int unsigned CHANNELS_PER_UNIT = 16
) (
    input  logic [rhlt_pkg::RES_W-1:0]  resource,
    input  logic [rhlt_pkg::CORE_W-1:0] core,
    output rhlt_pkg::dec_t              dec
);
    import rhlt_pkg::*;

    localparam logic [RES_W:0] RES_LIMIT = (RES_W + 1)'(NUM_RESOURCES);
    localparam logic [RES_W:0] CPU_EXT   = (RES_W + 1)'(CHANNELS_PER_UNIT);
    localparam logic [RES_W:0] CORE_LIM  = (RES_W + 1)'(NUM_CORES);

    logic [RES_W:0] res_ext;

    assign res_ext = {1'b0, resource};

    always_comb begin
        dec.in_range  = res_ext < RES_LIMIT;
        dec.unit1     = res_ext >= CPU_EXT;
        dec.core_ok   = (RES_W + 1)'(core) < CORE_LIM;
        dec.chan_full = dec.unit1 ? (resource - CPU_EXT[RES_W-1:0]) : resource;
    end

endmodule

/* rtl/core/rhlt_table.sv */
// Lock state table: per-core recursion counts and channel held flags.
`timescale 1ns / 1ps

module rhlt_table #(
    parameter int unsigned NUM_CORES         = 2,
    parameter int unsigned COUNT_LIMIT       = 255,
    parameter int unsigned CHANNELS_PER_UNIT = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        apply,
    input  logic [rhlt_pkg::OP_W-1:0]   op,
    input  logic [rhlt_pkg::CORE_W-1:0] core,
    input  rhlt_pkg::dec_t              dec,
    output rhlt_pkg::result_t           result
);
    import rhlt_pkg::*;

    // The core field is one bit, so at most two cores can ever reach the table
    localparam int unsigned EFF_CORES = (NUM_CORES > 2) ? 2 : NUM_CORES;
    localparam int unsigned CH_W = (CHANNELS_PER_UNIT > 1) ? $clog2(CHANNELS_PER_UNIT) : 1;
    localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(COUNT_LIMIT);

    logic [COUNT_W-1:0] count_reg [CHANNELS_PER_UNIT][EFF_CORES];
    logic               held_reg  [CHANNELS_PER_UNIT];

    logic [CH_W-1:0]    ch_idx;
    logic               core_idx;
    logic [COUNT_W-1:0] cnt;
    logic [COUNT_W-1:0] count_next;
    logic               count_we;
    logic               held_next;
    logic               held_we;

    assign ch_idx   = dec.chan_full[CH_W-1:0];
    assign core_idx = (EFF_CORES > 1) ? core : 1'b0;
    assign cnt      = count_reg[ch_idx][core_idx];

    always_comb begin
        result.status      = ST_OK;
        result.unit_id     = dec.unit1;
        result.channel     = dec.chan_full[CHAN_W-1:0];
        result.count_after = '0;
        count_next         = cnt;
        count_we           = 1'b0;
        held_next          = held_reg[ch_idx];
        held_we            = 1'b0;

        if (!dec.in_range) begin
            result.status  = ST_PARAM;
            result.unit_id = 1'b0;
            result.channel = '0;
        end else if (dec.unit1) begin
            result.status = ST_NOSUP;
        end else if (!dec.core_ok) begin
            result.status = ST_PARAM;
        end else if (op == OP_LOCK) begin
            if (cnt != '0) begin
                if (cnt >= LIMIT) begin
                    result.status      = ST_NOSUP;
                    result.count_after = cnt;
                end else begin
                    count_next         = cnt + 1'b1;
                    count_we           = 1'b1;
                    result.count_after = cnt + 1'b1;
                end
            end else if (held_reg[ch_idx]) begin
                result.status = ST_BUSY;
            end else begin
                // first lock by this core takes the channel
                count_next         = COUNT_W'(1);
                count_we           = 1'b1;
                held_next          = 1'b1;
                held_we            = 1'b1;
                result.count_after = COUNT_W'(1);
            end
        end else begin
            if (cnt == '0) begin
                result.status = ST_PARAM;
            end else begin
                count_next         = cnt - 1'b1;
                count_we           = 1'b1;
                result.count_after = cnt - 1'b1;
                if (cnt == COUNT_W'(1)) begin
                    held_next = 1'b0;
                    held_we   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS_PER_UNIT; i++) begin
                held_reg[i] <= 1'b0;
                for (int j = 0; j < EFF_CORES; j++) begin
                    count_reg[i][j] <= '0;
                end
            end
        end else if (apply) begin
            if (count_we) begin
                count_reg[ch_idx][core_idx] <= count_next;
            end
            if (held_we) begin
                held_reg[ch_idx] <= held_next;
            end
        end
    end

endmodule

/* rtl/core/recursive_hw_lock_table_core.sv */
// Top level of the recursive hardware lock table.
`timescale 1ns / 1ps
//
// Requests arrive on the s_ stream channel, one lock or unlock per transaction;
// every request gives exactly one response transaction on the m_ channel, in order.
// A request is captured in an input register. From there one pass of decode and
// table logic works out the status, updates the recursion count and the channel
// held flag, and loads the result register that drives the m_ channel. Throughput is one
// request per cycle while the receiver keeps m_tready high, because the count entry
// and held flag of a request are read and written within that single pass, so the
// next request always sees the updated table.
// When the receiver stalls, the result register holds its transaction and the
// input register still takes one more request; after that s_tready drops until
// m_tready returns.
// Reset (aresetn low, synchronous) empties both registers, clears all recursion
// counts and frees every channel; there is no clearing sweep afterwards.

module recursive_hw_lock_table_core #(
    parameter int unsigned NUM_RESOURCES     = 32,
    parameter int unsigned NUM_CORES         = 2,
    parameter int unsigned COUNT_LIMIT       = 255,
    parameter int unsigned CHANNELS_PER_UNIT = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // op [0], resource [6:1], core [7]
    input  logic [rhlt_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status [1:0], unit_id [2], channel [6:3], count_after [14:7], zero [15]
    output logic [rhlt_pkg::M_DATA_W-1:0]   m_tdata
);
    import rhlt_pkg::*;

    logic               in_valid_reg;
    logic [OP_W-1:0]    op_reg;
    logic [RES_W-1:0]   res_reg;
    logic [CORE_W-1:0]  core_reg;

    logic               out_valid_reg;
    result_t            out_reg;

    logic               advance;
    logic               apply;
    dec_t               dec;
    result_t            result;

    assign advance  = !out_valid_reg || m_tready;
    assign apply    = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            op_reg   <= s_tdata[0];
            res_reg  <= s_tdata[RES_W:1];
            core_reg <= s_tdata[RES_W+1];
        end
    end

    rhlt_decode #(
        .NUM_RESOURCES     (NUM_RESOURCES),
        .NUM_CORES         (NUM_CORES),
        .CHANNELS_PER_UNIT (CHANNELS_PER_UNIT)
    ) u_decode (
        .resource (res_reg),
        .core     (core_reg),
        .dec      (dec)
    );

    rhlt_table #(
        .NUM_CORES         (NUM_CORES),
        .COUNT_LIMIT       (COUNT_LIMIT),
        .CHANNELS_PER_UNIT (CHANNELS_PER_UNIT)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .apply   (apply),
        .op      (op_reg),
        .core    (core_reg),
        .dec     (dec),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (apply) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.count_after, out_reg.channel, out_reg.unit_id,
                       out_reg.status};

endmodule

/* rtl/core/rhlt_checker.sv */
// Port-level assertions for the lock table core, with the bind that attaches them.
`timescale 1ns / 1ps

module rhlt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rhlt_pkg::M_DATA_W-1:0] m_tdata
);
    import rhlt_pkg::*;

    logic [STATUS_W-1:0] st;
    logic [COUNT_W-1:0]  cnt;

    assign st  = m_tdata[STATUS_W-1:0];
    assign cnt = m_tdata[14:7];

    // a stalled response holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("response changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("response valid right after reset");

    // unit 1 is never served
    a_unit1: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> st == ST_NOSUP)
        else $error("unit 1 resource not answered as not supported");

    a_busy_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st == ST_BUSY || st == ST_PARAM) |-> cnt == '0)
        else $error("busy or parameter error with nonzero count");

    // no request, then an empty output with still no request: no response can appear
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tvalid && s_tready) ##1 (!m_tvalid && !(s_tvalid && s_tready))
        |=> !m_tvalid)
        else $error("response without request");

endmodule

bind recursive_hw_lock_table_core rhlt_checker u_rhlt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* sim/tb_top.sv */
// Self-checking testbench for the recursive hardware lock table core.
`timescale 1ns / 1ps

module tb_top;
    import rhlt_pkg::*;

    localparam int unsigned N_RES      = 32;
    localparam int unsigned N_CORES    = 2;
    localparam int unsigned CNT_LIMIT  = 255;
    localparam int unsigned CH_PER_U   = 16;
    localparam int unsigned STALL_MAX  = 4000;
    localparam int unsigned HOLD_LEN   = 300;
    localparam int unsigned ERR_PRINTS = 30;

    // Mirrors the lock table and holds the responses still owed by the DUT.
    class lock_scoreboard;
        logic [COUNT_W-1:0] rec_cnt [N_RES*N_CORES];
        bit                 held    [CH_PER_U];
        bit                 owner   [CH_PER_U];
        result_t            owed_q  [$];
        int                 errors;
        int                 n_req;
        int                 n_rsp;
        int                 n_sat;
        int                 st_hits [4];

        function new();
            foreach (rec_cnt[i]) rec_cnt[i] = '0;
            foreach (held[i]) held[i] = 1'b0;
            foreach (owner[i]) owner[i] = 1'b0;
            foreach (st_hits[i]) st_hits[i] = 0;
            errors = 0;
            n_req  = 0;
            n_rsp  = 0;
            n_sat  = 0;
        endfunction

        task report(input string msg);
            if (errors < ERR_PRINTS)
                $display("[%0t] ERROR: %s", $realtime, msg);
            errors++;
        endtask

        function int pending();
            return owed_q.size();
        endfunction

        // Applies one accepted request to the mirrored table.
        function void note_request(input logic [S_DATA_W-1:0] d);
            logic    op;
            int      res;
            int      core;
            int      ch;
            int      idx;
            int      cnt;
            result_t r;
            op   = d[0];
            res  = int'(d[6:1]);
            core = int'(d[7]);
            r    = '0;
            n_req++;
            if (res >= N_RES) begin
                r.status = ST_PARAM;
            end else begin
                r.unit_id = (res >= CH_PER_U);
                ch        = r.unit_id ? res - CH_PER_U : res;
                r.channel = ch[CHAN_W-1:0];
                if (r.unit_id) begin
                    r.status = ST_NOSUP;
                end else if (core >= N_CORES) begin
                    r.status = ST_PARAM;
                end else begin
                    idx = res * N_CORES + core;
                    cnt = int'(rec_cnt[idx]);
                    if (op == OP_LOCK) begin
                        if (cnt > 0) begin
                            if (cnt >= CNT_LIMIT) begin
                                r.status      = ST_NOSUP;
                                r.count_after = cnt[COUNT_W-1:0];
                                n_sat++;
                            end else begin
                                cnt++;
                                rec_cnt[idx]  = cnt[COUNT_W-1:0];
                                r.status      = ST_OK;
                                r.count_after = cnt[COUNT_W-1:0];
                            end
                        end else if (held[ch]) begin
                            r.status = ST_BUSY;
                        end else begin
                            held[ch]      = 1'b1;
                            owner[ch]     = core[0];
                            rec_cnt[idx]  = 8'd1;
                            r.status      = ST_OK;
                            r.count_after = 8'd1;
                        end
                    end else if (cnt == 0) begin
                        r.status = ST_PARAM;
                    end else begin
                        cnt--;
                        rec_cnt[idx] = cnt[COUNT_W-1:0];
                        if (cnt == 0) begin
                            held[ch]  = 1'b0;
                            owner[ch] = 1'b0;
                        end
                        r.status      = ST_OK;
                        r.count_after = cnt[COUNT_W-1:0];
                    end
                end
            end
            st_hits[r.status]++;
            owed_q.push_back(r);
        endfunction

        task check_response(input logic [M_DATA_W-1:0] d);
            result_t want;
            n_rsp++;
            if (owed_q.size() == 0) begin
                report($sformatf("unexpected response 0x%04h", d));
            end else begin
                want = owed_q.pop_front();
                if (d[1:0] !== want.status)
                    report($sformatf("rsp %0d status %0d, want %0d",
                                     n_rsp, d[1:0], want.status));
                if (d[2] !== want.unit_id)
                    report($sformatf("rsp %0d unit_id %0d, want %0d",
                                     n_rsp, d[2], want.unit_id));
                if (d[6:3] !== want.channel)
                    report($sformatf("rsp %0d channel %0d, want %0d",
                                     n_rsp, d[6:3], want.channel));
                if (d[14:7] !== want.count_after)
                    report($sformatf("rsp %0d count_after %0d, want %0d",
                                     n_rsp, d[14:7], want.count_after));
                if (d[15] !== 1'b0)
                    report($sformatf("rsp %0d pad bit is %b", n_rsp, d[15]));
            end
        endtask
    endclass

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    lock_scoreboard lock_sb;
    int             send_idle = 0;
    int             recv_idle = 0;
    bit             hold_req  = 1'b0;
    int             hold_left = 0;
    int             stall_cycles = 0;

    recursive_hw_lock_table_core #(
        .NUM_RESOURCES     (N_RES),
        .NUM_CORES         (N_CORES),
        .COUNT_LIMIT       (CNT_LIMIT),
        .CHANNELS_PER_UNIT (CH_PER_U)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial lock_sb = new();

    // Receiver: random backpressure, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // Monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                lock_sb.note_request(s_tdata);
            if (m_tvalid && m_tready)
                lock_sb.check_response(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_MAX) begin
                    $display("watchdog: no transaction for %0d cycles", STALL_MAX);
                    $display("recursive_hw_lock_table_core: mismatch");
                    $finish;
                end
            end
        end
    end

    task send_req(input logic op, input int res, input logic core);
        s_tdata  <= {core, res[RES_W-1:0], op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // A clock edge first, so the monitor has noted the last accepted request.
    task wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (lock_sb.pending() != 0) @(posedge aclk);
    endtask

    // Many requests to contended low channels, some recursive lock/unlock sessions, some noise.
    task run_random(input int n_items, input int lock_pct);
        int   left;
        int   p;
        int   res;
        int   depth;
        logic core;
        left = n_items;
        while (left > 0) begin
            core = 1'($urandom_range(1));
            if ($urandom_range(99) < 25) begin
                depth = $urandom_range(1, 6);
                res   = $urandom_range(CH_PER_U - 1);
                repeat (depth) send_req(OP_LOCK, res, core);
                repeat (depth) send_req(OP_UNLOCK, res, core);
                left -= 2 * depth;
            end else begin
                p = $urandom_range(99);
                if (p < 10)
                    res = $urandom_range(CH_PER_U, 63);
                else if (p < 55)
                    res = $urandom_range(3);
                else
                    res = $urandom_range(CH_PER_U - 1);
                send_req(($urandom_range(99) < lock_pct) ? OP_LOCK : OP_UNLOCK, res, core);
                left--;
            end
        end
    endtask

    // Free one channel completely, then drive one core's count into the limit and back.
    task run_saturation();
        int   res;
        logic core;
        int   n_mine;
        int   n_other;
        wait_drained();
        res     = $urandom_range(CH_PER_U - 1);
        core    = 1'($urandom_range(1));
        n_other = int'(lock_sb.rec_cnt[res * N_CORES + int'(!core)]);
        n_mine  = int'(lock_sb.rec_cnt[res * N_CORES + int'(core)]);
        repeat (n_other) send_req(OP_UNLOCK, res, !core);
        repeat (n_mine) send_req(OP_UNLOCK, res, core);
        repeat (CNT_LIMIT + 2) send_req(OP_LOCK, res, core);
        repeat (CNT_LIMIT + 1) send_req(OP_UNLOCK, res, core);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle = 21;
        recv_idle = 82;

        // directed: recursion, busy, release, unit 1, out of range
        send_req(OP_LOCK,   0,  1'b0);
        send_req(OP_LOCK,   0,  1'b1);
        send_req(OP_LOCK,   0,  1'b0);
        send_req(OP_UNLOCK, 0,  1'b1);
        send_req(OP_UNLOCK, 0,  1'b0);
        send_req(OP_UNLOCK, 0,  1'b0);
        send_req(OP_UNLOCK, 0,  1'b0);
        send_req(OP_LOCK,   0,  1'b1);
        send_req(OP_UNLOCK, 0,  1'b1);
        send_req(OP_LOCK,   15, 1'b1);
        send_req(OP_LOCK,   15, 1'b0);
        send_req(OP_UNLOCK, 15, 1'b0);
        send_req(OP_UNLOCK, 15, 1'b1);
        send_req(OP_LOCK,   16, 1'b0);
        send_req(OP_UNLOCK, 16, 1'b1);
        send_req(OP_LOCK,   31, 1'b1);
        send_req(OP_UNLOCK, 31, 1'b0);
        send_req(OP_LOCK,   32, 1'b0);
        send_req(OP_UNLOCK, 63, 1'b1);
        send_req(OP_LOCK,   47, 1'b1);
        send_req(OP_LOCK,   42, 1'b0);
        send_req(OP_LOCK,   10, 1'b1);
        send_req(OP_UNLOCK, 10, 1'b1);

        run_random(480, 55);
        wait_drained();

        send_idle = 82;
        recv_idle = 21;
        run_random(500, 45);
        wait_drained();

        send_idle = 0;
        recv_idle = 0;
        hold_req  = 1'b1;
        run_random(200, 55);
        run_saturation();
        run_random(230, 50);

        wait_drained();
        repeat (20) @(posedge aclk);

        $display("covered %0d requests / %0d responses: ok %0d, param err %0d, busy %0d",
                 lock_sb.n_req, lock_sb.n_rsp, lock_sb.st_hits[ST_OK],
                 lock_sb.st_hits[ST_PARAM], lock_sb.st_hits[ST_BUSY]);
        $display("not supported %0d (of which %0d at the count limit), %0d errors",
                 lock_sb.st_hits[ST_NOSUP], lock_sb.n_sat, lock_sb.errors);
        if (lock_sb.errors == 0 && lock_sb.pending() == 0) begin
            $display("recursive_hw_lock_table_core: match");
        end else begin
            $display("recursive_hw_lock_table_core: mismatch");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/rhlt_pkg.sv
rtl/core/rhlt_decode.sv
rtl/core/rhlt_table.sv
rtl/core/recursive_hw_lock_table_core.sv
rtl/core/rhlt_checker.sv
sim/tb_top.sv
